// File: rtl/sphere_vertex_generator_top_defines.svh
// Assertion macros shared by the sphere vertex generator RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH
`define SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH

// checked outside reset
`define SVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define SVG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/svg_pkg.sv
// Shared types, widths and constants of the sphere vertex generator.
// No dependencies.
`default_nettype none

package svg_pkg;

  localparam int RES_W              = 11;
  localparam int RADIUS_W           = 16;
  localparam int POS_W              = 24;
  localparam int TEX_W              = 17;
  localparam int ANG_W              = 32;
  localparam int TRIG_W             = 32;
  localparam int CS_W               = 34;
  localparam int QUO_W              = 34;
  localparam int ATAN_LEN           = 24;
  localparam int MIN_RESOLUTION     = 2;
  localparam int DEF_MAX_RESOLUTION = 1024;
  localparam int DEF_CORDIC_STAGES  = 16;

  localparam logic [RADIUS_W-1:0] RADIUS_RST  = 16'd256;
  localparam logic [RES_W-1:0]    RES_RST     = 11'd64;
  localparam logic [TRIG_W-1:0]   CORDIC_GAIN = 32'd652032874;

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_RES    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic [RES_W-1:0]    res;
    logic [RES_W-1:0]    den;
  } cfg_t;

  // atan(2^-i) as a fraction of one full turn, 2^32 per turn
  function automatic logic [ANG_W-1:0] atan_turn(input int unsigned i);
    logic [ANG_W-1:0] a;
    case (i)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051D;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2E;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2F9;
      15:      a = 32'h0000517C;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A2F;
      19:      a = 32'h00000517;
      20:      a = 32'h0000028B;
      21:      a = 32'h00000145;
      22:      a = 32'h000000A2;
      23:      a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/svg_regs.sv
// Configuration register file with APB-style access.
// Depends on svg_pkg; produces the clamped resolution and divisor.
`default_nettype none

module svg_regs #(
  parameter int MAX_RESOLUTION = svg_pkg::DEF_MAX_RESOLUTION
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output svg_pkg::cfg_t     cfg_o
);
  import svg_pkg::*;

  logic [RADIUS_W-1:0] radius_q;
  logic [RES_W-1:0]    res_q;
  logic [RES_W-1:0]    res_eff;
  reg_idx_e            idx;
  logic                wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      res_q    <= RES_RST;
    end else if (wr) begin
      case (idx)
        REG_RADIUS: radius_q <= pwdata[RADIUS_W-1:0];
        REG_RES:    res_q    <= pwdata[RES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RADIUS: prdata = {{(32-RADIUS_W){1'b0}}, radius_q};
      REG_RES:    prdata = {{(32-RES_W){1'b0}}, res_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    res_eff = res_q;
    if (res_q < RES_W'(MIN_RESOLUTION)) begin
      res_eff = RES_W'(MIN_RESOLUTION);
    end else if (32'(res_q) > MAX_RESOLUTION) begin
      res_eff = RES_W'(MAX_RESOLUTION);
    end
  end

  assign cfg_o.radius = radius_q;
  assign cfg_o.res    = res_eff;
  assign cfg_o.den    = res_eff - 1'b1;

endmodule

`default_nettype wire

// File: rtl/svg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on svg_pkg; the caller must keep the divisor static while items flow; the block does not enforce it.
`default_nettype none

module svg_div #(
  parameter int NW = 43,
  parameter int QW = svg_pkg::QUO_W
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [NW-1:0]             num_i,
  input  wire logic [svg_pkg::RES_W-1:0] den_i,
  output logic [QW-1:0]                  quo_o
);
  import svg_pkg::*;

  localparam int EW = NW + QW;

  logic [EW-1:0]    ext;
  logic [RES_W-1:0] rem_q [QW+1];
  logic [QW-1:0]    lo_q  [QW+1];
  logic [QW-1:0]    quo_q [QW+1];

  assign ext = EW'(num_i);

  // quotient is known to fit QW bits, so the bits above start below den
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RES_W'(ext >> QW);
      lo_q[0]  <= ext[QW-1:0];
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RES_W:0] trial;
    logic [RES_W:0] diff;
    logic           ge;

    assign trial = {rem_q[k], lo_q[k][QW-1-k]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[RES_W-1:0] : trial[RES_W-1:0];
        lo_q[k+1]  <= lo_q[k];
        quo_q[k+1] <= {quo_q[k][QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW];

endmodule

`default_nettype wire

// File: rtl/svg_cordic.sv
// Unrolled rotation-mode CORDIC giving cosine and sine in Q1.30.
// Depends on svg_pkg for the arctangent table and the gain.
`default_nettype none

module svg_cordic #(
  parameter int STAGES = svg_pkg::DEF_CORDIC_STAGES
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [svg_pkg::ANG_W-1:0]   ang_i,
  output logic signed [svg_pkg::TRIG_W-1:0] cos_o,
  output logic signed [svg_pkg::TRIG_W-1:0] sin_o
);
  import svg_pkg::*;

  localparam int NS = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

  logic signed [CS_W-1:0]  x_q    [NS+1];
  logic signed [CS_W-1:0]  y_q    [NS+1];
  logic signed [ANG_W:0]   z_q    [NS+1];
  logic                    flip_q [NS+1];
  logic [ANG_W-1:0]        folded;
  logic                    flip;

  // fold the angle by half a turn into [-pi/2, pi/2), negate the outputs later
  assign flip   = (ang_i[ANG_W-1:ANG_W-2] == 2'd1) || (ang_i[ANG_W-1:ANG_W-2] == 2'd2);
  assign folded = flip ? (ang_i - {1'b1, {(ANG_W-1){1'b0}}}) : ang_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= $signed({{(CS_W-TRIG_W){1'b0}}, CORDIC_GAIN});
      y_q[0]    <= '0;
      z_q[0]    <= $signed({folded[ANG_W-1], folded});
      flip_q[0] <= flip;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic signed [ANG_W:0] atan;
    assign atan = $signed({1'b0, atan_turn(i)});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][ANG_W]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan;
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  logic signed [CS_W-1:0] xo;
  logic signed [CS_W-1:0] yo;
  assign xo = flip_q[NS] ? -x_q[NS] : x_q[NS];
  assign yo = flip_q[NS] ? -y_q[NS] : y_q[NS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= xo[TRIG_W-1:0];
      sin_o <= yo[TRIG_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/svg_mul.sv
// Radius and trig product pipeline: four stages, product then round.
// Depends on svg_pkg for field widths.
`default_nettype none

module svg_mul (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [svg_pkg::RADIUS_W-1:0]  radius_i,
  input  wire logic signed [svg_pkg::TRIG_W-1:0] ce_i,
  input  wire logic signed [svg_pkg::TRIG_W-1:0] se_i,
  input  wire logic signed [svg_pkg::TRIG_W-1:0] ca_i,
  input  wire logic signed [svg_pkg::TRIG_W-1:0] sa_i,
  input  wire logic [svg_pkg::TEX_W-1:0]     u_i,
  input  wire logic [svg_pkg::TEX_W-1:0]     v_i,
  output logic [svg_pkg::POS_W-1:0]          pos_x_o,
  output logic [svg_pkg::POS_W-1:0]          pos_y_o,
  output logic [svg_pkg::POS_W-1:0]          pos_z_o,
  output logic [svg_pkg::TEX_W-1:0]          tex_u_o,
  output logic [svg_pkg::TEX_W-1:0]          tex_v_o
);
  import svg_pkg::*;

  localparam int P1_W = RADIUS_W + 1 + TRIG_W;
  localparam int T_W  = P1_W - 30;
  localparam int P2_W = T_W + TRIG_W;

  logic signed [P1_W-1:0]   py_p_q, pt_p_q;
  logic signed [TRIG_W-1:0] ca1_q, sa1_q, ca2_q, sa2_q;
  logic [TEX_W-1:0]         u_q [3];
  logic [TEX_W-1:0]         v_q [3];
  logic signed [T_W-1:0]    t_q;
  logic [POS_W-1:0]         py2_q, py3_q;
  logic signed [P2_W-1:0]   px_p_q, pz_p_q;
  logic signed [P1_W-1:0]   py_r, pt_r;
  logic signed [P2_W-1:0]   px_r, pz_r;

  // round half up at bit 30
  assign py_r = (py_p_q + (P1_W'(1) <<< 29)) >>> 30;
  assign pt_r = (pt_p_q + (P1_W'(1) <<< 29)) >>> 30;
  assign px_r = (px_p_q + (P2_W'(1) <<< 29)) >>> 30;
  assign pz_r = (pz_p_q + (P2_W'(1) <<< 29)) >>> 30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      py_p_q  <= $signed({1'b0, radius_i}) * se_i;
      pt_p_q  <= $signed({1'b0, radius_i}) * ce_i;
      ca1_q   <= ca_i;
      sa1_q   <= sa_i;
      u_q[0]  <= u_i;
      v_q[0]  <= v_i;

      t_q     <= pt_r[T_W-1:0];
      py2_q   <= py_r[POS_W-1:0];
      ca2_q   <= ca1_q;
      sa2_q   <= sa1_q;
      u_q[1]  <= u_q[0];
      v_q[1]  <= v_q[0];

      px_p_q  <= t_q * ca2_q;
      pz_p_q  <= t_q * sa2_q;
      py3_q   <= py2_q;
      u_q[2]  <= u_q[1];
      v_q[2]  <= v_q[1];

      pos_x_o <= px_r[POS_W-1:0];
      pos_z_o <= pz_r[POS_W-1:0];
      pos_y_o <= py3_q;
      tex_u_o <= u_q[2];
      tex_v_o <= v_q[2];
    end
  end

endmodule

`default_nettype wire

// File: rtl/sphere_vertex_generator_top.sv
// Sphere vertex generator: one UV-sphere vertex per (ring, point) transaction.
// Uses svg_pkg, svg_regs, svg_div, svg_cordic and svg_mul.
//
// Input stream: s_axis carries ring_index and point_index; one transaction
// per grid point. Output stream: m_axis carries pos_x, pos_y, pos_z (Q15.8)
// and tex_u, tex_v (Q1.16), one transaction per input, in order.
// Configuration: APB-style port, radius at 0x0 and resolution at 0x4;
// write only while no transaction is in flight.
// Throughput: one transaction per cycle while the receiver does not stall.
// Pipeline: input register, 35 divider stages, min(CORDIC_STAGES, ATAN_LEN) + 2
// rotation stages, 4 multiply stages.
// Reset clears all valid bits and loads radius 1.0 and resolution 64.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; empty slots still fill while m_axis_tvalid is low.
`default_nettype none

`include "sphere_vertex_generator_top_defines.svh"

module sphere_vertex_generator_top #(
  parameter int MAX_RESOLUTION = svg_pkg::DEF_MAX_RESOLUTION,
  parameter int CORDIC_STAGES  = svg_pkg::DEF_CORDIC_STAGES
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [23:0]  s_axis_tdata,  // ring_index[10:0], point_index[21:11]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [111:0]      m_axis_tdata   // pos_x, pos_y, pos_z, tex_u, tex_v
);
  import svg_pkg::*;

  localparam int NS   = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int CLAT = NS + 2;
  localparam int LAT  = 1 + (QUO_W + 1) + CLAT + 4;
  localparam int AZ_W = RES_W + 32;
  localparam int EL_W = RES_W + 31;
  localparam int TX_W = RES_W + 16;

  cfg_t             cfg;
  logic             en;
  logic [LAT-1:0]   vld_q;
  logic [RES_W-1:0] ring_in, point_in, ring_q, point_q;

  svg_regs #(.MAX_RESOLUTION(MAX_RESOLUTION)) u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // advance everywhere unless a finished result waits
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  assign ring_in  = s_axis_tdata[10:0];
  assign point_in = s_axis_tdata[21:11];

  // clamp indices to the resolution
  always_ff @(posedge clk_i) begin
    if (en) begin
      ring_q  <= (ring_in > cfg.res) ? cfg.res : ring_in;
      point_q <= (point_in > cfg.res) ? cfg.res : point_in;
    end
  end

  logic [AZ_W-1:0]  az_num;
  logic [EL_W-1:0]  el_num;
  logic [TX_W-1:0]  u_num, v_num;
  logic [QUO_W-1:0] az_quo, el_quo, u_quo, v_quo;

  assign az_num = {ring_q, 32'b0} + AZ_W'(cfg.den >> 1);
  assign el_num = {point_q, 31'b0} + EL_W'(cfg.den >> 1);
  assign u_num  = {ring_q, 16'b0} + TX_W'(cfg.res >> 1);
  assign v_num  = {point_q, 16'b0} + TX_W'(cfg.res >> 1);

  svg_div #(.NW(AZ_W), .QW(QUO_W)) u_div_az (
    .clk_i, .en_i(en), .num_i(az_num), .den_i(cfg.den), .quo_o(az_quo));
  svg_div #(.NW(EL_W), .QW(QUO_W)) u_div_el (
    .clk_i, .en_i(en), .num_i(el_num), .den_i(cfg.den), .quo_o(el_quo));
  svg_div #(.NW(TX_W), .QW(QUO_W)) u_div_u (
    .clk_i, .en_i(en), .num_i(u_num), .den_i(cfg.res), .quo_o(u_quo));
  svg_div #(.NW(TX_W), .QW(QUO_W)) u_div_v (
    .clk_i, .en_i(en), .num_i(v_num), .den_i(cfg.res), .quo_o(v_quo));

  logic [ANG_W-1:0]         az_ang, el_ang;
  logic signed [TRIG_W-1:0] ce, se, ca, sa;

  assign az_ang = az_quo[ANG_W-1:0];
  assign el_ang = 32'h4000_0000 - el_quo[ANG_W-1:0];

  svg_cordic #(.STAGES(NS)) u_cordic_el (
    .clk_i, .en_i(en), .ang_i(el_ang), .cos_o(ce), .sin_o(se));
  svg_cordic #(.STAGES(NS)) u_cordic_az (
    .clk_i, .en_i(en), .ang_i(az_ang), .cos_o(ca), .sin_o(sa));

  // hold texture coordinates alongside the CORDIC stages
  logic [TEX_W-1:0] u_dly_q [CLAT];
  logic [TEX_W-1:0] v_dly_q [CLAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_dly_q[0] <= u_quo[TEX_W-1:0];
      v_dly_q[0] <= v_quo[TEX_W-1:0];
      for (int i = 1; i < CLAT; i++) begin
        u_dly_q[i] <= u_dly_q[i-1];
        v_dly_q[i] <= v_dly_q[i-1];
      end
    end
  end

  logic [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [TEX_W-1:0] tex_u, tex_v;

  svg_mul u_mul (
    .clk_i, .en_i(en), .radius_i(cfg.radius),
    .ce_i(ce), .se_i(se), .ca_i(ca), .sa_i(sa),
    .u_i(u_dly_q[CLAT-1]), .v_i(v_dly_q[CLAT-1]),
    .pos_x_o(pos_x), .pos_y_o(pos_y), .pos_z_o(pos_z),
    .tex_u_o(tex_u), .tex_v_o(tex_v)
  );

  assign m_axis_tdata = {6'b0, tex_v, tex_u, pos_z, pos_y, pos_x};

  `SVG_ASSERT(a_stall_holds_pipe, (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q), "valid pipeline moved while output stalled")
  `SVG_ASSERT(a_accept_enters, (s_axis_tvalid && s_axis_tready) |=> vld_q[0], "accepted transaction not captured")
  `SVG_ASSERT(a_res_floor, (cfg.res >= RES_W'(MIN_RESOLUTION)) && (cfg.den == cfg.res - 1'b1), "effective resolution or divisor out of range")
  `SVG_ASSERT_ALWAYS(a_pready_high, pready, "configuration port not ready")

endmodule

`default_nettype wire
